>>> sv/fad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fad_pkg
// Shared types and constants for the Fenwick absolute distance sum block.
// ----------------------------------------------------------------------------
package fad_pkg;

  localparam int SIZE   = 1024;
  localparam int ADDR_W = $clog2(SIZE);
  localparam int POS_W  = ADDR_W + 2;
  localparam int KEY_W  = 11;
  localparam int OP_W   = 2;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 48;
  localparam int OUT_W  = 41;

  localparam logic [POS_W-1:0] SIZE_POS = POS_W'(SIZE);

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

  // Prefix walks of a query, in order
  typedef logic [1:0] phase_t;
  localparam phase_t PH_BELOW = 2'd0;  // keys 1..k-1
  localparam phase_t PH_AT    = 2'd1;  // keys 1..k
  localparam phase_t PH_TOTAL = 2'd2;  // whole range

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
  } ent_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY_RD,
    ST_QRY_ACC,
    ST_QRY_FOLD,
    ST_QRY_MUL,
    ST_QRY_OUT
  } state_t;

  typedef struct packed {
    logic   clr;    // write zero at clear address, advance
    logic   load;   // capture transaction
    logic   rd;     // read tree entry at current position
    logic   upd;    // write back updated entry, move up
    logic   acc;    // add entry into prefix, move down
    logic   fold;   // fold finished prefix into totals
    phase_t phase;
    logic   mul;    // scale count total by key
    logic   emit;   // register result and strobe
  } cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic in_range;
    logic clr_done;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/fad_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fad_ctrl
// Sequencer for clearing, tree updates and three-walk prefix queries.
// ----------------------------------------------------------------------------
module fad_ctrl
  import fad_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire op_t  in_operation,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      phase_r <= PH_BELOW;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          phase_nxt = PH_BELOW;
          unique case (in_operation) inside
            OP_INSERT, OP_REMOVE: state_nxt = ST_UPD_RD;
            OP_QUERY:             state_nxt = ST_QRY_RD;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_UPD_RD:   state_nxt = sts.in_range ? ST_UPD_WR : ST_IDLE;
      ST_UPD_WR:   state_nxt = ST_UPD_RD;
      ST_QRY_RD:   state_nxt = sts.pos_zero ? ST_QRY_FOLD : ST_QRY_ACC;
      ST_QRY_ACC:  state_nxt = ST_QRY_RD;
      ST_QRY_FOLD: begin
        if (phase_r == PH_TOTAL) begin
          state_nxt = ST_QRY_MUL;
        end else begin
          state_nxt = ST_QRY_RD;
          phase_nxt = phase_r + 2'd1;
        end
      end
      ST_QRY_MUL:  state_nxt = ST_QRY_OUT;
      ST_QRY_OUT:  state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.phase = phase_r;
    unique case (state_r)
      ST_CLEAR:    cmd.clr  = 1'b1;
      ST_IDLE:     cmd.load = start;
      ST_UPD_RD:   cmd.rd   = sts.in_range;
      ST_UPD_WR:   cmd.upd  = 1'b1;
      ST_QRY_RD:   cmd.rd   = !sts.pos_zero;
      ST_QRY_ACC:  cmd.acc  = 1'b1;
      ST_QRY_FOLD: cmd.fold = 1'b1;
      ST_QRY_MUL:  cmd.mul  = 1'b1;
      ST_QRY_OUT:  cmd.emit = 1'b1;
      default:     cmd      = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

>>> sv/fad_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fad_dp
// Tree memory, walk position, prefix accumulators and result arithmetic.
// ----------------------------------------------------------------------------
module fad_dp
  import fad_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  input  wire op_t              in_operation,
  input  wire logic [KEY_W-1:0] in_key,
  output sts_t                  sts,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_distance_sum
);

  // one entry per tree node; node SIZE lives at address zero
  ent_t mem [SIZE];

  ent_t              rd_data_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [POS_W-1:0]  pos_r;
  logic [KEY_W-1:0]  key_r;
  logic              dec_r;
  logic [CNT_W-1:0]  cacc_r;
  logic [OUT_W-1:0]  sacc_r;
  logic [OUT_W-1:0]  dacc_r;
  logic [OUT_W-1:0]  prod_r;
  logic [OUT_W-1:0]  out_r;
  logic              out_valid_r;

  logic [POS_W-1:0]       low_bit;
  logic [POS_W-1:0]       key_ext;
  logic [POS_W-1:0]       key_m1;
  logic [POS_W-1:0]       pos_below;
  logic [POS_W-1:0]       pos_at;
  ent_t                   wr_ent;
  logic [OUT_W-1:0]       cacc_ext;
  logic [OUT_W+KEY_W-1:0] prod_full;

  assign low_bit   = pos_r & (~pos_r + POS_W'(1));
  assign key_ext   = POS_W'(in_key);
  assign key_m1    = key_ext - POS_W'(1);
  assign pos_below = (in_key == '0) ? '0 : ((key_m1 > SIZE_POS) ? SIZE_POS : key_m1);
  assign pos_at    = (POS_W'(key_r) > SIZE_POS) ? SIZE_POS : POS_W'(key_r);
  assign cacc_ext  = {{(OUT_W-CNT_W){cacc_r[CNT_W-1]}}, cacc_r};
  assign prod_full = dacc_r * key_r;

  always_comb begin
    if (dec_r) begin
      wr_ent.cnt = rd_data_r.cnt - CNT_W'(1);
      wr_ent.sum = rd_data_r.sum - SUM_W'(key_r);
    end else begin
      wr_ent.cnt = rd_data_r.cnt + CNT_W'(1);
      wr_ent.sum = rd_data_r.sum + SUM_W'(key_r);
    end
  end

  // single port: clear or update write, otherwise read
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.upd) begin
      mem[pos_r[ADDR_W-1:0]] <= wr_ent;
    end else if (cmd.rd) begin
      rd_data_r <= mem[pos_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_key;
      dec_r  <= (in_operation == OP_REMOVE);
      pos_r  <= (in_operation == OP_QUERY) ? pos_below : key_ext;
      cacc_r <= '0;
      sacc_r <= '0;
      dacc_r <= '0;
    end else if (cmd.upd) begin
      pos_r <= pos_r + low_bit;
    end else if (cmd.acc) begin
      pos_r  <= pos_r - low_bit;
      cacc_r <= cacc_r + rd_data_r.cnt;
      // sum total counts positive, both lower prefixes negative
      if (cmd.phase == PH_TOTAL) begin
        sacc_r <= sacc_r + rd_data_r.sum[OUT_W-1:0];
      end else begin
        sacc_r <= sacc_r - rd_data_r.sum[OUT_W-1:0];
      end
    end else if (cmd.fold) begin
      cacc_r <= '0;
      if (cmd.phase == PH_TOTAL) begin
        dacc_r <= dacc_r - cacc_ext;
      end else begin
        dacc_r <= dacc_r + cacc_ext;
      end
      pos_r <= (cmd.phase == PH_BELOW) ? pos_at : SIZE_POS;
    end
    if (cmd.mul) prod_r <= prod_full[OUT_W-1:0];
    if (cmd.emit) out_r <= prod_r + sacc_r;
  end

  assign sts.pos_zero = (pos_r == '0);
  assign sts.in_range = (pos_r != '0) && (pos_r <= SIZE_POS);
  assign sts.clr_done = (clr_cnt_r == '1);

  assign out_valid        = out_valid_r;
  assign out_distance_sum = out_r;

endmodule
`default_nettype wire

>>> sv/fenwick_abs_distance_sum.sv
`default_nettype none
// Insert/remove: busy while each tree node walked upward (at most 11 nodes) is read and written back.
// Query: a read and an accumulate per node plus an end check and a fold for each of three
//   prefix walks (key-1, key, whole range), then a multiply step and a result step.
// The strobe is high in the first cycle with busy low; the next transaction may start then.
// The receiver cannot stall; out_valid is high for exactly one cycle per query.
// Reset: a clearing pass zeroes all 1024 tree memory entries while busy is high.
// ----------------------------------------------------------------------------
// fenwick_abs_distance_sum
// Multiset of keys in count/sum Fenwick trees; answers absolute distance sums.
// ----------------------------------------------------------------------------
module fenwick_abs_distance_sum
  import fad_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [OP_W-1:0]  in_operation,
  input  wire logic [KEY_W-1:0] in_key,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_distance_sum
);

  cmd_t cmd;
  sts_t sts;

  fad_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  fad_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_key           (in_key),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_distance_sum (out_distance_sum)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_no_result_non_query: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != OP_QUERY) |=> !out_valid)
    else $error("result strobe after a non-query transaction");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd && (cmd.upd || cmd.clr)))
    else $error("tree memory read and write in the same cycle");

endmodule
`default_nettype wire
